// ----- hw/rtl/rrs_pkg.sv -----
// rrs_pkg: shared types and constants for the reorder receiver with sack
// used by rrs_slot_table and reorder_receiver_with_sack; no dependencies

package rrs_pkg;

   // reorder window, a power of two so the slot is the low bits of the seq
   localparam int WINDOW    = 32;
   localparam int SLOT_W    = $clog2(WINDOW);
   localparam int MAX_LEN   = 1024;
   localparam int SACK_SPAN = 32;
   localparam int SPAN_W    = $clog2(SACK_SPAN + 1);

   localparam int SEQ_W = 32;
   localparam int REF_W = 16;
   localparam int LEN_W = 11;

   // result kinds on rsp_tuser
   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [REF_W-1:0] pref;
      logic [SEQ_W-1:0] seq;
   } entry_type;

   // table control from the sequencer
   typedef struct packed {
      logic              ins_en;   // insert at wr_slot if the slot is free
      logic              clr_en;   // release wr_slot after a drain
      logic [SLOT_W-1:0] wr_slot;
      logic [SLOT_W-1:0] rd_slot;
   } tbl_ctl_type;

endpackage

// ----- hw/rtl/reorder_receiver_with_sack.sv -----
// reorder_receiver_with_sack: selective-repeat receiver, in-order delivery and sack
// depends on rrs_pkg and rrs_slot_table
//
//   channel  dir  fields (lsb first)                          handshake
//   req_     in   tdata: seq_num, payload_ref, payload_len   tvalid/tready
//   rsp_     out  tdata: out_seq, out_ref, out_len, sack     tvalid/tready
//                 tuser: kind, tlast: last
//
// a packet is accepted and then classified; an in-order packet is delivered, and each
// buffered successor is then read and checked until a read misses or the window bound
// ends the drain; every packet that is not dropped then gets the sack scan (setup, one table
// read per bitmap bit through the single memory read port, the compare of the last read
// and a closing step) and the ack; an oversized packet is dropped with no ack
// reset is synchronous; it clears the state, the slot valid flags, next expected and the output and check valid flags
// a stalled rsp_ side holds the sequencer where it must emit; req_tready is low meanwhile

module reorder_receiver_with_sack (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // seq_num[31:0], payload_ref[47:32], payload_len[58:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // out_seq[31:0], out_ref[47:32], out_len[58:48],
                                    // sack_bits[90:59]
   output logic        rsp_tuser,   // kind[0]
   output logic        rsp_tlast
);

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CLASS    = 3'd1;
   localparam logic [2:0] ST_DRAIN_RD = 3'd2;
   localparam logic [2:0] ST_DRAIN_CK = 3'd3;
   localparam logic [2:0] ST_SACK_INI = 3'd4;
   localparam logic [2:0] ST_SACK     = 3'd5;
   localparam logic [2:0] ST_ACK      = 3'd6;

   localparam int SEQ_W  = rrs_pkg::SEQ_W;
   localparam int SLOT_W = rrs_pkg::SLOT_W;
   localparam int SPAN_W = rrs_pkg::SPAN_W;

   logic [2:0] state_ff, state_in;

   // latched packet
   rrs_pkg::entry_type pkt_ff, pkt_in;

   // receive state
   logic [SEQ_W-1:0]  next_exp_ff, next_exp_in;
   logic [SLOT_W-1:0] drain_cnt_ff, drain_cnt_in;

   // sack scan: probe issues reads, chk compares in the following cycle
   logic [SEQ_W-1:0]  probe_ff, probe_in;
   logic [SPAN_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [SEQ_W-1:0]  chk_seq_ff, chk_seq_in;
   logic [rrs_pkg::SACK_SPAN-1:0] sack_ff, sack_in;

   // output register
   logic        rsp_vld_ff, rsp_vld_in;
   logic [95:0] rsp_data_ff, rsp_data_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        out_free;

   // table interface
   rrs_pkg::tbl_ctl_type tbl_ctl;
   rrs_pkg::entry_type   tbl_rd;
   logic [SEQ_W-1:0]     cmp_seq;
   logic                 tbl_hit;

   // window test on the latched packet
   logic [SEQ_W-1:0] win_end;
   logic             in_order, in_window, too_long;

   assign win_end   = next_exp_ff + SEQ_W'(rrs_pkg::WINDOW);
   assign in_order  = (pkt_ff.seq == next_exp_ff);
   assign in_window = (pkt_ff.seq > next_exp_ff) && (pkt_ff.seq < win_end);
   assign too_long  = (pkt_ff.len > rrs_pkg::LEN_W'(rrs_pkg::MAX_LEN));

   assign out_free   = !rsp_vld_ff || rsp_tready;
   // no transfer is taken while reset is held
   assign req_tready = (state_ff == ST_IDLE) && !reset;

   // compare target: drain looks for next expected, the scan for the probed seq
   assign cmp_seq = (state_ff == ST_SACK) ? chk_seq_ff : next_exp_ff;

   always_comb begin
      state_in     = state_ff;
      pkt_in       = pkt_ff;
      next_exp_in  = next_exp_ff;
      drain_cnt_in = drain_cnt_ff;
      probe_in     = probe_ff;
      scan_cnt_in  = scan_cnt_ff;
      chk_vld_in   = 1'b0;
      chk_seq_in   = chk_seq_ff;
      sack_in      = sack_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;

      tbl_ctl.ins_en  = 1'b0;
      tbl_ctl.clr_en  = 1'b0;
      tbl_ctl.wr_slot = pkt_ff.seq[SLOT_W-1:0];
      tbl_ctl.rd_slot = next_exp_ff[SLOT_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pkt_in.seq  = req_tdata[31:0];
               pkt_in.pref = req_tdata[47:32];
               pkt_in.len  = req_tdata[58:48];
               state_in    = ST_CLASS;
            end
         end
         ST_CLASS: begin
            if (too_long) begin
               // oversized packet: dropped without an ack
               state_in = ST_IDLE;
            end else if (in_order) begin
               if (out_free) begin
                  rsp_vld_in   = 1'b1;
                  rsp_kind_in  = rrs_pkg::KIND_DELIVER;
                  rsp_last_in  = 1'b0;
                  rsp_data_in  = {37'd0, pkt_ff.len, pkt_ff.pref, pkt_ff.seq};
                  next_exp_in  = next_exp_ff + 1'b1;
                  drain_cnt_in = '0;
                  state_in     = ST_DRAIN_RD;
               end
            end else begin
               // early packet goes into its slot if free; duplicates fall through
               tbl_ctl.ins_en = in_window;
               state_in       = ST_SACK_INI;
            end
         end
         ST_DRAIN_RD: begin
            state_in = ST_DRAIN_CK;
         end
         ST_DRAIN_CK: begin
            if (!tbl_hit) begin
               state_in = ST_SACK_INI;
            end else if (out_free) begin
               rsp_vld_in      = 1'b1;
               rsp_kind_in     = rrs_pkg::KIND_DELIVER;
               rsp_last_in     = 1'b0;
               rsp_data_in     = {37'd0, tbl_rd.len, tbl_rd.pref, next_exp_ff};
               tbl_ctl.clr_en  = 1'b1;
               tbl_ctl.wr_slot = next_exp_ff[SLOT_W-1:0];
               next_exp_in     = next_exp_ff + 1'b1;
               drain_cnt_in    = drain_cnt_ff + 1'b1;
               // drain stops after window-1 buffered successors
               if (drain_cnt_ff == SLOT_W'(rrs_pkg::WINDOW - 2)) begin
                  state_in = ST_SACK_INI;
               end else begin
                  state_in = ST_DRAIN_RD;
               end
            end
         end
         ST_SACK_INI: begin
            probe_in    = next_exp_ff + 1'b1;
            scan_cnt_in = '0;
            sack_in     = '0;
            state_in    = ST_SACK;
         end
         ST_SACK: begin
            tbl_ctl.rd_slot = probe_ff[SLOT_W-1:0];
            if (scan_cnt_ff != SPAN_W'(rrs_pkg::SACK_SPAN)) begin
               probe_in    = probe_ff + 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
               chk_vld_in  = 1'b1;
               chk_seq_in  = probe_ff;
            end
            // bits shift in from the top so the first probe lands in bit 0
            if (chk_vld_ff) begin
               sack_in = {tbl_hit, sack_ff[rrs_pkg::SACK_SPAN-1:1]};
            end
            if (scan_cnt_ff == SPAN_W'(rrs_pkg::SACK_SPAN) && !chk_vld_ff) begin
               state_in = ST_ACK;
            end
         end
         ST_ACK: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_kind_in = rrs_pkg::KIND_ACK;
               rsp_last_in = 1'b1;
               rsp_data_in = {5'd0, sack_ff, 27'd0, next_exp_ff};
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         next_exp_ff <= '0;
         rsp_vld_ff  <= 1'b0;
         chk_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         next_exp_ff <= next_exp_in;
         rsp_vld_ff  <= rsp_vld_in;
         chk_vld_ff  <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff       <= pkt_in;
      drain_cnt_ff <= drain_cnt_in;
      probe_ff     <= probe_in;
      scan_cnt_ff  <= scan_cnt_in;
      chk_seq_ff   <= chk_seq_in;
      sack_ff      <= sack_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   rrs_slot_table u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tbl_ctl),
      .wr_entry (pkt_ff),
      .cmp_seq  (cmp_seq),
      .rd_entry (tbl_rd),
      .hit      (tbl_hit)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- hw/rtl/rrs_slot_table.sv -----
// rrs_slot_table: reorder slot memory with valid flags and the shared seq compare
// depends on rrs_pkg

module rrs_slot_table (
   input  logic                     clock,
   input  logic                     reset,
   input  rrs_pkg::tbl_ctl_type     ctl,
   input  rrs_pkg::entry_type       wr_entry,
   input  logic [rrs_pkg::SEQ_W-1:0] cmp_seq,
   output rrs_pkg::entry_type       rd_entry,
   output logic                     hit
);

   rrs_pkg::entry_type mem [rrs_pkg::WINDOW];

   logic [rrs_pkg::WINDOW-1:0] valid_ff;
   logic [rrs_pkg::WINDOW-1:0] valid_in;
   logic [rrs_pkg::SLOT_W-1:0] rd_slot_ff;
   rrs_pkg::entry_type         rd_entry_ff;
   logic                       do_ins;

   assign do_ins = ctl.ins_en && !valid_ff[ctl.wr_slot];

   always_comb begin
      valid_in = valid_ff;
      if (do_ins) begin
         valid_in[ctl.wr_slot] = 1'b1;
      end else if (ctl.clr_en) begin
         valid_in[ctl.wr_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_ins) begin
         mem[ctl.wr_slot] <= wr_entry;
      end
      rd_entry_ff <= mem[ctl.rd_slot];
      rd_slot_ff  <= ctl.rd_slot;
   end

   assign rd_entry = rd_entry_ff;
   assign hit      = valid_ff[rd_slot_ff] && (rd_entry_ff.seq == cmp_seq);

endmodule

// ----- bench/reorder_receiver_with_sack_tb.sv -----
`timescale 1ns / 100ps
// reorder_receiver_with_sack_tb: self-checking bench for the selective-repeat receiver with sack
// depends on rrs_pkg and the reorder_receiver_with_sack rtl with its rrs_slot_table

module reorder_receiver_with_sack_tb;

   localparam int   SEQ_W        = rrs_pkg::SEQ_W;
   localparam int   REF_W        = rrs_pkg::REF_W;
   localparam int   LEN_W        = rrs_pkg::LEN_W;
   localparam int   SLOT_W       = rrs_pkg::SLOT_W;
   localparam int   WINDOW       = rrs_pkg::WINDOW;
   localparam int   MAX_LEN      = rrs_pkg::MAX_LEN;
   localparam int   SACK_SPAN    = rrs_pkg::SACK_SPAN;
   localparam logic KIND_DELIVER = rrs_pkg::KIND_DELIVER;
   localparam logic KIND_ACK     = rrs_pkg::KIND_ACK;

   localparam int TARGET_PKTS    = 220;
   localparam int HOLDOFF_AT     = 50;     // results checked when the long rsp_ stall begins
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;   // cycles with no transfer on either side
   localparam int TAIL_CYCLES    = 200;    // quiet tail after the last owed result has been matched

   // how eagerly a side moves: no waits, 0..17 waits, or an occasional wait
   typedef enum int {PACE_EAGER, PACE_RANDOM, PACE_SPARSE} pace_type;

   // one packet waiting to go out on req_, with its own gap and pause flag
   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic [REF_W-1:0] pref;
      logic [LEN_W-1:0] len;
      logic [4:0]       gap;
      logic             hold;   // wait until every due result has come
   } pkt_type;

   typedef struct packed {
      logic                 kind;
      logic [SEQ_W-1:0]     seq;
      logic [REF_W-1:0]     pref;
      logic [LEN_W-1:0]     len;
      logic [SACK_SPAN-1:0] sack;
      logic                 last;
   } result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // seq_num[31:0], payload_ref[47:32], payload_len[58:48]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;         // out_seq[31:0], out_ref[47:32], out_len[58:48],
                                   // sack_bits[90:59]
   logic        rsp_tuser;         // kind[0]
   logic        rsp_tlast;         // last

   reorder_receiver_with_sack u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------
   // shadow of the receiver: next expected number and reorder table
   // ---------------------------------------------------------------
   logic [SEQ_W-1:0] rx_next;
   logic             rx_held [WINDOW];
   logic [SEQ_W-1:0] rx_hseq [WINDOW];
   logic [REF_W-1:0] rx_href [WINDOW];
   logic [LEN_W-1:0] rx_hlen [WINDOW];

   result_type due_results [$];    // results still owed by the block, oldest first
   pkt_type    pkt_backlog [$];    // packets not yet offered on req_

   int results_predicted = 0;      // written by the driver only
   int predicted_r       = 0;      // registered copy for the end-of-run wait
   int results_seen      = 0;      // matched results, written by the monitor only
   int pkts_sent         = 0;
   int pkts_dropped      = 0;
   int longest_drain     = 0;
   int mismatches        = 0;
   int n_pkts            = 0;
   int pkts_counted      = 0;      // generated packets that the block answers
   int idle_cycles       = 0;

   pace_type send_mode = PACE_EAGER;
   int       send_left = 0;

   function automatic int draw_wait(input pace_type mode);
      case (mode)
         PACE_EAGER:  draw_wait = 0;
         PACE_RANDOM: draw_wait = $urandom_range(0, 17);
         default:     draw_wait = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
      endcase
   endfunction

   function automatic result_type mk_result(input logic kind, input logic [SEQ_W-1:0] seq,
                                            input logic [REF_W-1:0] pref,
                                            input logic [LEN_W-1:0] len,
                                            input logic [SACK_SPAN-1:0] sack);
      result_type r;
      r.kind = kind;
      r.seq  = seq;
      r.pref = pref;
      r.len  = len;
      r.sack = sack;
      r.last = (kind == KIND_ACK);
      return r;
   endfunction

   // drop of oversized packets; else in-order delivery, drain of buffered successors, buffering, then the ack
   task automatic reorder_and_ack(input pkt_type p);
      logic [SEQ_W-1:0]     win_end;
      logic [SEQ_W-1:0]     s;
      logic [SLOT_W-1:0]    k;
      logic [SACK_SPAN-1:0] sack;
      int                   drained;
      int                   i;
      logic                 more;
      if (p.len > MAX_LEN) begin
         // oversized: dropped without even an ack, state untouched
         pkts_dropped++;
      end else begin
         win_end = rx_next + WINDOW;
         if (p.seq == rx_next) begin
            due_results.push_back(mk_result(KIND_DELIVER, p.seq, p.pref, p.len, '0));
            results_predicted++;
            rx_next = rx_next + 1;
            drained = 0;
            more    = 1'b1;
            // at most WINDOW-1 successors follow the in-order packet
            while (more && drained < WINDOW - 1) begin
               k = rx_next[SLOT_W-1:0];
               if (rx_held[k] && rx_hseq[k] == rx_next) begin
                  due_results.push_back(mk_result(KIND_DELIVER, rx_next, rx_href[k],
                                                  rx_hlen[k], '0));
                  results_predicted++;
                  rx_held[k] = 1'b0;
                  rx_next    = rx_next + 1;
                  drained++;
               end else begin
                  more = 1'b0;
               end
            end
            if (drained > longest_drain) longest_drain = drained;
         end else if (p.seq > rx_next && p.seq < win_end) begin
            // plain unsigned window test; an occupied slot keeps its first packet
            k = p.seq[SLOT_W-1:0];
            if (!rx_held[k]) begin
               rx_held[k] = 1'b1;
               rx_hseq[k] = p.seq;
               rx_href[k] = p.pref;
               rx_hlen[k] = p.len;
            end
         end
         sack = '0;
         for (i = 0; i < SACK_SPAN; i++) begin
            s = rx_next + 1 + i;
            k = s[SLOT_W-1:0];
            if (rx_held[k] && rx_hseq[k] == s) sack = sack | (SACK_SPAN'(1) << i);
         end
         due_results.push_back(mk_result(KIND_ACK, rx_next, '0, '0, sack));
         results_predicted++;
      end
   endtask

   task automatic add_pkt(input logic [SEQ_W-1:0] seq, input int pref, input int len,
                          input logic hold);
      pkt_type p;
      // the sender pace changes every few packets, eager stretches included
      if (send_left == 0) begin
         send_mode = pace_type'($urandom_range(0, 2));
         send_left = $urandom_range(5, 30);
      end
      send_left--;
      p.seq  = seq;
      p.pref = REF_W'(pref);
      p.len  = LEN_W'(len);
      p.gap  = 5'(draw_wait(send_mode));
      p.hold = hold;
      pkt_backlog.push_back(p);
      if (len <= MAX_LEN) pkts_counted++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %h, got %h", name, want_v, got_v);
         mismatches++;
      end
   endtask

   initial begin : clockgen
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // stimulus: directed packets, then random windows, holes and noise
   // ---------------------------------------------------------------
   initial begin : stimulus
      int               order [];
      int               n, lo, j, t, tmp, sel;
      logic             late_pause_done;
      logic [SEQ_W-1:0] gen_next;   // where the generator believes next expected is
      logic [SEQ_W-1:0] span_end;   // one past the highest hole left behind
      order   = new[WINDOW];
      rx_next = '0;
      rx_held = '{default: 1'b0};

      // directed part
      add_pkt(0, 'h0000, 0, 1'b0);                      // in order, smallest fields
      add_pkt(2, 'hFFFF, MAX_LEN, 1'b0);                // ahead, largest length
      add_pkt(3, 'h1234, 1, 1'b0);
      add_pkt(3, 'hABCD, 7, 1'b0);                      // slot already taken
      add_pkt(1, 'h0001, 512, 1'b0);                    // in order, drains 2 and 3
      add_pkt(0, 'h5555, 100, 1'b0);                    // old duplicate, ack only
      add_pkt(4, 'h0F0F, MAX_LEN + 1, 1'b0);            // oversized, dropped
      add_pkt(4, 'hF0F0, 'h7FF, 1'b0);                  // oversized, all length bits
      add_pkt(4 + WINDOW - 1, 'h00FF, 3, 1'b0);         // last seq inside the window
      add_pkt(4 + WINDOW, 'hFF00, 4, 1'b0);             // first seq past the window
      add_pkt(32'hFFFF_FFFF, 'h8000, 5, 1'b0);          // largest seq, far outside
      add_pkt(32'h8000_0000, 'h7FFF, 6, 1'b0);
      add_pkt(4, 'h2222, 64, 1'b0);                     // in order, sack shows the edge
      add_pkt(5, 'h3333, MAX_LEN - 1, 1'b1);            // sender pause before this one
      gen_next = 6;
      span_end = 4 + WINDOW;
      late_pause_done = 1'b0;

      // random part: mostly full windows in shuffled order
      while (pkts_counted < TARGET_PKTS) begin
         if (!late_pause_done && pkts_counted >= TARGET_PKTS / 2) begin
            add_pkt(gen_next - 1, $urandom_range(0, 16'hFFFF), $urandom_range(0, MAX_LEN),
                    1'b1);
            late_pause_done = 1'b1;
         end
         sel = $urandom_range(0, 9);
         if (sel <= 5) begin
            // a window from gen_next; long enough to cover any holes left behind
            lo = (span_end > gen_next) ? int'(span_end - gen_next) : 1;
            if ($urandom_range(0, 4) == 0) n = WINDOW;
            else n = $urandom_range(lo, (lo > 12) ? lo : 12);
            for (j = 0; j < n; j++) order[j] = j;
            for (j = n - 1; j > 0; j--) begin
               t        = $urandom_range(0, j);
               tmp      = order[j];
               order[j] = order[t];
               order[t] = tmp;
            end
            // often the in-order packet comes last so that the whole window drains
            if ($urandom_range(0, 2) == 0) begin
               for (j = 0; j < n - 1; j++) begin
                  if (order[j] == 0) begin
                     order[j]     = order[n - 1];
                     order[n - 1] = 0;
                  end
               end
            end
            for (j = 0; j < n; j++) begin
               add_pkt(gen_next + order[j], $urandom_range(0, 16'hFFFF),
                       $urandom_range(0, MAX_LEN), 1'b0);
               if ($urandom_range(0, 7) == 0)
                  add_pkt(gen_next + order[$urandom_range(0, j)], $urandom_range(0, 16'hFFFF),
                          $urandom_range(0, MAX_LEN), 1'b0);
            end
            gen_next = gen_next + n;
         end else if (sel == 6) begin
            // broken window: the in-order packet never comes, holes remain
            n = $urandom_range(2, WINDOW - 1);
            for (j = n - 1; j > 0; j--) begin
               if ($urandom_range(0, 9) < 7)
                  add_pkt(gen_next + j, $urandom_range(0, 16'hFFFF),
                          $urandom_range(0, MAX_LEN), 1'b0);
            end
            if (gen_next + n > span_end) span_end = gen_next + n;
         end else if (sel == 7) begin
            add_pkt(gen_next + $urandom_range(0, 3), $urandom_range(0, 16'hFFFF),
                    $urandom_range(MAX_LEN + 1, 11'h7FF), 1'b0);
         end else if (sel == 8) begin
            if ($urandom_range(0, 1) == 0)
               add_pkt(gen_next - $urandom_range(1, 64), $urandom_range(0, 16'hFFFF),
                       $urandom_range(0, MAX_LEN), 1'b0);
            else
               add_pkt(gen_next + WINDOW + $urandom_range(0, 5000),
                       $urandom_range(0, 16'hFFFF), $urandom_range(0, MAX_LEN), 1'b0);
         end else begin
            add_pkt($urandom, $urandom_range(0, 16'hFFFF), $urandom_range(0, MAX_LEN), 1'b0);
         end
      end
      n_pkts = pkt_backlog.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // all packets taken and every owed result matched, then a quiet tail
      while (!(pkts_sent == n_pkts && results_seen == predicted_r)) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         $error("%0d results never arrived", due_results.size());
         mismatches++;
      end
      $display("covered %0d packets (%0d oversized and dropped), %0d results checked",
               pkts_sent, pkts_dropped, results_seen);
      $display("longest drain behind an in-order packet: %0d buffered successors",
               longest_drain);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // req_ driver: offers backlog packets, predicts at each transfer
   // ---------------------------------------------------------------
   pkt_type cur_pkt;
   int      gap_cnt = 0;

   always @(posedge clock) begin : driver
      int   waited;
      logic took;
      if (reset) begin
         req_tvalid  <= 1'b0;
         gap_cnt     <= 0;
         pkts_sent   <= 0;
         predicted_r <= 0;
      end else begin
         took   = req_tvalid && req_tready;
         waited = gap_cnt;
         if (took) begin
            reorder_and_ack(cur_pkt);
            waited = 0;
         end else if (!req_tvalid && waited < 64) begin
            waited++;
         end
         // a new packet goes out once the line is free and its gap has passed;
         // a paused packet also waits for every owed result
         if (took || !req_tvalid) begin
            if (pkt_backlog.size() != 0 && waited >= pkt_backlog[0].gap &&
                (!pkt_backlog[0].hold || (!took && results_seen == results_predicted))) begin
               cur_pkt = pkt_backlog.pop_front();
               req_tdata  <= {5'b0, cur_pkt.len, cur_pkt.pref, cur_pkt.seq};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         gap_cnt     <= waited;
         predicted_r <= results_predicted;
         if (took) pkts_sent <= pkts_sent + 1;
      end
   end

   // ---------------------------------------------------------------
   // rsp_ monitor: random stalls, one long hold-off, field checks
   // ---------------------------------------------------------------
   int       stall_cnt   = 0;
   int       holdoff_cnt = 0;
   pace_type recv_mode   = PACE_EAGER;
   int       recv_left   = 0;

   always @(posedge clock) begin : monitor
      result_type want;
      int         st, ho;
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_cnt   <= 0;
         holdoff_cnt <= 0;
      end else begin
         st = stall_cnt;
         ho = holdoff_cnt;
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("unexpected result: kind %0d out_seq %h", rsp_tuser, rsp_tdata[31:0]);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("out_seq", want.seq, rsp_tdata[31:0]);
               check_field("out_ref", 32'(want.pref), 32'(rsp_tdata[47:32]));
               check_field("out_len", 32'(want.len), 32'(rsp_tdata[58:48]));
               check_field("sack_bits", want.sack, rsp_tdata[90:59]);
               check_field("last", 32'(want.last), 32'(rsp_tlast));
               results_seen <= results_seen + 1;
               // one long stall so the block backs up and req_tready drops
               if (results_seen + 1 == HOLDOFF_AT) ho = HOLDOFF_CYCLES;
            end
            if (recv_left == 0) begin
               recv_mode = pace_type'($urandom_range(0, 2));
               recv_left = $urandom_range(5, 40);
            end
            recv_left--;
            st = draw_wait(recv_mode);
         end else if (!rsp_tready) begin
            if (ho > 0) ho--;
            else if (st > 0) st--;
         end
         rsp_tready  <= (ho == 0 && st == 0);
         stall_cnt   <= st;
         holdoff_cnt <= ho;
      end
   end

   // ---------------------------------------------------------------
   // watchdog: too long without any transfer ends the run
   // ---------------------------------------------------------------
   always @(posedge clock) begin : activity
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: %0d cycles without a transfer", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
   end

endmodule
